### design/amvp_pkg.sv
// Package for the adjacency matrix vector product block.
// Holds sizes, the command codes and the controller state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amvp_pkg;

  localparam int NODES     = 16;
  localparam int IDX_W     = 4;
  localparam int CELLS     = NODES * NODES;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int WEIGHT_W  = 16;
  localparam int PROD_W    = 2 * WEIGHT_W;
  localparam int SUM_W     = 40;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic signed [WEIGHT_W-1:0] ABSENT_WEIGHT = -16'sd1;

  typedef enum logic [1:0] {
    CMD_ADD_EDGE  = 2'd0,
    CMD_TRANSPOSE = 2'd1,
    CMD_LOAD_VEC  = 2'd2,
    CMD_COMPUTE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WRITE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### design/adjacency_matrix_vector_product.sv
// Top level of the adjacency matrix vector product block.
// Depends on amvp_pkg for sizes, command codes and the state type.
//
// Use: commands enter on the s_axis channel, one beat each. tuser carries the
// command (add edge, transpose, load vector element, compute); tdata carries
// the node indices and the 16-bit value. Results leave on the m_axis channel,
// one beat per column: tdata carries the column index and its 40-bit sum,
// tlast marks the final column of a product.
// Timing: transpose and vector load finish when their beat is taken; add edge
// reads the cell, then writes it if absent. Compute walks the weight memory
// one cell per cycle while it reads a column: 16 reads per column, then the
// product and accumulator registers drain and the column sum is emitted.
// No new command is taken until the current one is finished.
// Reset: all cells absent (per-cell valid bits cleared at once), vector zero,
// view not transposed; no clearing pass. When the receiver stalls, the
// output register holds its beat and the walk waits before the next column.
`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_vector_product
  import amvp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [3:0] first_index, [7:4] second_index, [23:8] value
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [3:0] column_index, [43:4] column_sum, [47:44] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

  state_t state, state_next;

  logic [WEIGHT_W-1:0] weight_mem [CELLS];
  logic [CELLS-1:0]    cell_valid;
  logic [WEIGHT_W-1:0] rd_data;
  logic                rd_valid;

  logic signed [WEIGHT_W-1:0] vec [NODES];
  logic signed [WEIGHT_W-1:0] vec_q;

  logic                transposed;
  logic [IDX_W-1:0]    row;
  logic [IDX_W-1:0]    col;
  logic [ADDR_W-1:0]   edge_addr;
  logic [WEIGHT_W-1:0] edge_val;

  logic                p1_active, p1_last;
  logic                p2_active, p2_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;

  logic [IDX_W-1:0]    out_col;
  logic signed [SUM_W-1:0] out_sum;
  logic                out_last;

  logic                in_beat;
  cmd_t                cmd;
  logic [IDX_W-1:0]    first_index;
  logic [IDX_W-1:0]    second_index;
  logic [WEIGHT_W-1:0] value;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic                out_load;
  logic                out_free;
  logic                cell_absent;

  assign cmd          = cmd_t'(s_axis_tuser);
  assign first_index  = s_axis_tdata[IDX_W-1:0];
  assign second_index = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign value        = s_axis_tdata[2*IDX_W+WEIGHT_W-1:2*IDX_W];
  assign in_beat      = s_axis_tvalid && s_axis_tready;
  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign cell_absent  = !rd_valid || (rd_data == ABSENT_WEIGHT);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (cmd == CMD_ADD_EDGE && first_index != second_index) begin
            state_next = ST_EDGE_WRITE;
          end else if (cmd == CMD_COMPUTE) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_EDGE_WRITE: state_next = ST_IDLE;
      ST_RUN: begin
        if (row == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (p2_active && p2_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (col == LAST_IDX) ? ST_IDLE : ST_RUN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = {row, col};
    wr_en         = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_en         = s_axis_tvalid && (cmd == CMD_ADD_EDGE);
        rd_addr       = transposed ? {second_index, first_index}
                                   : {first_index, second_index};
      end
      ST_EDGE_WRITE: wr_en = cell_absent;
      ST_RUN: begin
        rd_en   = 1'b1;
        rd_addr = transposed ? {col, row} : {row, col};
      end
      ST_DRAIN: ;
      ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // weight memory: one read, one write port, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_mem[edge_addr] <= edge_val;
    end
    if (rd_en) begin
      rd_data <= weight_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        cell_valid[edge_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= cell_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && cmd == CMD_ADD_EDGE) begin
      edge_addr <= rd_addr;
      edge_val  <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transposed <= 1'b0;
      for (int k = 0; k < NODES; k++) begin
        vec[k] <= '0;
      end
    end else if (in_beat) begin
      if (cmd == CMD_TRANSPOSE) begin
        transposed <= !transposed;
      end
      if (cmd == CMD_LOAD_VEC) begin
        vec[first_index] <= value;
      end
    end
  end

  // walk counters: row advances per read, column per emitted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      if (in_beat && cmd == CMD_COMPUTE) begin
        row <= '0;
        col <= '0;
      end else begin
        if (state == ST_RUN) begin
          row <= row + IDX_W'(1);
        end
        if (out_load) begin
          col <= col + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      vec_q <= vec[row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_active <= 1'b0;
      p1_last   <= 1'b0;
      p2_active <= 1'b0;
      p2_last   <= 1'b0;
    end else begin
      p1_active <= (state == ST_RUN);
      p1_last   <= (row == LAST_IDX);
      p2_active <= p1_active;
      p2_last   <= p1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_active) begin
      if (cell_absent) begin
        prod <= '0;
      end else begin
        prod <= $signed(rd_data) * vec_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (out_load) begin
      acc <= '0;
    end else if (p2_active) begin
      acc <= acc + SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col  <= col;
      out_sum  <= acc;
      out_last <= (col == LAST_IDX);
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - SUM_W - IDX_W)'(0), out_sum, out_col};
  assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for adjacency_matrix_vector_product.
// Drives random and directed command beats, predicts the column sums in a local
// matrix model and checks every result beat; depends on amvp_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import amvp_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 500;

  typedef struct {
    cmd_t                 cmd;
    logic [IDX_W-1:0]     src;
    logic [IDX_W-1:0]     dst;
    logic signed [15:0]   value;
    int unsigned          gap;
  } command_beat_t;

  typedef struct {
    logic [IDX_W-1:0]     column;
    logic [SUM_W-1:0]     sum;
    logic                 last;
  } column_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  adjacency_matrix_vector_product dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Matrix model and the column sums still owed by the block
  logic signed [15:0] weight_cells [NODES][NODES];
  logic signed [15:0] vector_elems [NODES];
  logic               view_flipped;
  column_result_t     column_sums_due [$];
  command_beat_t      pending_beats [$];

  int errors = 0;
  int total_beats = 0;
  int beats_accepted = 0;
  int results_checked = 0;
  int products_run = 0;
  int edges_stored = 0;
  int edges_dropped = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("testbench: mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
    errors++;
  endtask

  function automatic void apply_command(input command_beat_t b);
    column_result_t r;
    longint acc;
    logic signed [15:0] w;
    case (b.cmd)
      CMD_ADD_EDGE: begin
        w = view_flipped ? weight_cells[b.dst][b.src] : weight_cells[b.src][b.dst];
        if (b.src != b.dst && w == ABSENT_WEIGHT) begin
          if (view_flipped) weight_cells[b.dst][b.src] = b.value;
          else weight_cells[b.src][b.dst] = b.value;
          edges_stored++;
        end else begin
          edges_dropped++;
        end
      end
      CMD_TRANSPOSE: view_flipped = !view_flipped;
      CMD_LOAD_VEC: vector_elems[b.src] = b.value;
      CMD_COMPUTE: begin
        products_run++;
        for (int j = 0; j < NODES; j++) begin
          acc = 0;
          for (int i = 0; i < NODES; i++) begin
            w = view_flipped ? weight_cells[j][i] : weight_cells[i][j];
            if (w != ABSENT_WEIGHT) acc += longint'(w) * longint'(vector_elems[i]);
          end
          r.column = IDX_W'(j);
          r.sum = acc[SUM_W-1:0];
          r.last = (j == NODES - 1);
          column_sums_due.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_beat(input cmd_t cmd, input int src, input int dst,
                                     input int value, input int unsigned gap);
    command_beat_t b;
    b.cmd = cmd;
    b.src = IDX_W'(src);
    b.dst = IDX_W'(dst);
    b.value = 16'(value);
    b.gap = gap;
    pending_beats.push_back(b);
    total_beats++;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 11))
      0: return -32768;
      1: return 32767;
      2: return -1;
      3: return 0;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // Driver: one command beat offered at a time, with an optional gap before it
  command_beat_t staged_beat;
  command_beat_t offered_beat;
  logic          have_staged = 1'b0;
  int unsigned   gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(offered_beat);
        beats_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!have_staged && pending_beats.size() > 0) begin
          staged_beat = pending_beats.pop_front();
          have_staged = 1'b1;
          gap_left = staged_beat.gap;
        end
        if (have_staged && gap_left == 0) begin
          offered_beat = staged_beat;
          have_staged = 1'b0;
          s_axis_tdata <= {staged_beat.value, staged_beat.dst, staged_beat.src};
          s_axis_tuser <= staged_beat.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          if (have_staged) gap_left--;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, two long hold-offs, field-by-field check
  column_result_t want;
  int unsigned    hold_left = 0;
  int             long_holds = 0;
  logic           steady_ready = 1'b0;
  int unsigned    r_pick;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (column_sums_due.size() == 0) begin
          report_mismatch("unexpected result beat", m_axis_tdata, 0);
        end else begin
          want = column_sums_due.pop_front();
          if (m_axis_tdata[3:0] != want.column)
            report_mismatch("column_index", m_axis_tdata[3:0], want.column);
          if (m_axis_tdata[43:4] != want.sum)
            report_mismatch("column_sum", m_axis_tdata[43:4], want.sum);
          if (m_axis_tlast != want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
        results_checked++;
        if (results_checked % 32 == 0) steady_ready = ($urandom_range(0, 2) == 0);
      end
      r_pick = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if ((results_checked == 20 && long_holds == 0) ||
                   (results_checked == 90 && long_holds == 1)) begin
        long_holds++;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (steady_ready || r_pick < 75) begin
        m_axis_tready <= 1'b1;
      end else if (r_pick < 97) begin
        hold_left = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        hold_left = $urandom_range(15, 40);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: no handshake for %0d cycles, giving up", IDLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    logic burst;
    for (int i = 0; i < NODES; i++) begin
      vector_elems[i] = '0;
      for (int k = 0; k < NODES; k++) weight_cells[i][k] = ABSENT_WEIGHT;
    end
    view_flipped = 1'b0;

    // Directed: extremes, self loop, occupied cell, a -1 weight, orientation
    queue_beat(CMD_LOAD_VEC, 0, 0, 32767, 0);
    queue_beat(CMD_LOAD_VEC, 15, 0, -32768, 0);
    queue_beat(CMD_LOAD_VEC, 5, 15, -1, 1);
    queue_beat(CMD_LOAD_VEC, 1, 0, 1, 0);
    queue_beat(CMD_ADD_EDGE, 0, 15, 32767, 0);
    queue_beat(CMD_ADD_EDGE, 15, 0, -32768, 0);
    queue_beat(CMD_ADD_EDGE, 3, 3, 5, 2);
    queue_beat(CMD_ADD_EDGE, 0, 15, 7, 0);
    queue_beat(CMD_ADD_EDGE, 5, 1, -1, 0);
    queue_beat(CMD_ADD_EDGE, 5, 1, -32768, 0);
    queue_beat(CMD_ADD_EDGE, 1, 14, 0, 0);
    queue_beat(CMD_ADD_EDGE, 15, 5, -32768, 0);
    queue_beat(CMD_COMPUTE, 0, 0, 0, 0);
    queue_beat(CMD_TRANSPOSE, 15, 15, -1, 0);
    queue_beat(CMD_ADD_EDGE, 15, 0, 100, 0);
    queue_beat(CMD_ADD_EDGE, 2, 9, -300, 0);
    queue_beat(CMD_LOAD_VEC, 9, 0, -32768, 0);
    queue_beat(CMD_COMPUTE, 15, 15, -1, 3);
    queue_beat(CMD_TRANSPOSE, 0, 0, 0, 0);
    queue_beat(CMD_LOAD_VEC, 15, 0, 32767, 0);
    queue_beat(CMD_COMPUTE, 0, 0, 0, 0);

    // Random: mostly edges and loads, a product every few beats
    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      queue_beat(cmd_t'(pick < 42 ? CMD_ADD_EDGE :
                        pick < 80 ? CMD_LOAD_VEC :
                        pick < 89 ? CMD_TRANSPOSE : CMD_COMPUTE),
                 $urandom_range(0, 15), $urandom_range(0, 15), pick_value(),
                 burst ? 0 : pick_gap());
    end
    queue_beat(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15), pick_value(), 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (beats_accepted < total_beats) @(negedge clk);
    while (column_sums_due.size() > 0) @(negedge clk);
    repeat (40) @(posedge clk);

    $display("testbench: %0d command beats, %0d products, %0d column sums checked",
             beats_accepted, products_run, results_checked);
    $display("testbench: %0d edges stored, %0d edge adds dropped, %0d long receiver holds",
             edges_stored, edges_dropped, long_holds);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: %0d mismatches", errors);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/amvp_pkg.sv
design/adjacency_matrix_vector_product.sv
tb/testbench.sv
